@@ design/linear_probe_hash_table_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LPHT_CHECK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("linear probe hash table: check failed");

// Checked on every clock edge, reset included.
`define LPHT_CHECK_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) (expr)) \
      else $error("linear probe hash table: check failed during reset");

`endif

@@ design/lpht_pkg.sv @@
`default_nettype none
package lpht_pkg;

   localparam int MAX_SLOTS_DEFAULT = 128;
   localparam int KEY_W             = 50;
   localparam int HANDLE_W          = 32;
   localparam int SIZE_W            = 8;
   localparam int OP_W              = 2;
   localparam int STATUS_W          = 2;
   localparam int SLOT_OUT_W        = 7;
   localparam int COUNT_OUT_W       = 8;
   localparam int MARK_W            = 2;
   localparam int KEY_CNT_W         = $clog2(KEY_W);

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 8'd17;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

   localparam int            CSR_ADDR_W        = 3;
   localparam logic [2:0]    CSR_TABLE_SIZE    = 3'd0;

   typedef struct packed {
      logic [MARK_W-1:0]   mark;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } slot_type;

endpackage
`default_nettype wire

@@ design/lpht_mod.sv @@
`default_nettype none
module lpht_mod
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [KEY_W-1:0]             dividend,
   input  wire logic [$clog2(MAX_SLOTS):0]   divisor,
   output logic                              done,
   output logic [$clog2(MAX_SLOTS)-1:0]      remainder
);

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int NW = SW + 1;

   logic                 busy_ff;
   logic                 done_ff;
   logic [KEY_CNT_W-1:0] cnt_ff;
   logic [KEY_W-1:0]     dq_ff;
   logic [NW-1:0]        div_ff;
   logic [NW-1:0]        rem_ff;
   logic [NW:0]          trial;
   logic [NW:0]          diff;
   logic [NW-1:0]        rem_in;

   // One quotient bit a cycle, restoring form.
   always_comb begin
      trial  = {rem_ff, dq_ff[KEY_W-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[NW-1:0] : trial[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == KEY_CNT_W'(KEY_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[KEY_W-2:0], 1'b0};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SW-1:0];

endmodule
`default_nettype wire

@@ design/linear_probe_hash_table_unit.sv @@
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   operation, lookup_key, entry_handle
// rsp      out        rsp_valid/rsp_stall   status, found_handle, slot_index, entry_count
// csr      in         csr_psel/csr_penable  table_size at byte address 0
//
// The key modulo table size comes from a bit-serial divider, one key bit a cycle;
// then each slot is probed through the slot memory port, and the result is loaded
// once probing ends, after at most as many probes as the clamped table size. One item is
// worked at a time; the next one may be accepted the cycle after the result is loaded.
// After reset a clearing pass writes every slot of the slot memory empty; req_stall
// stays high meanwhile. A stalled result holds its register; the next item may
// still be accepted and is held at its end until the register frees.
`default_nettype none
module linear_probe_hash_table_unit
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [OP_W-1:0]         req_operation,
   input  wire logic [KEY_W-1:0]        req_lookup_key,
   input  wire logic [HANDLE_W-1:0]     req_entry_handle,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [HANDLE_W-1:0]          rsp_found_handle,
   output logic [SLOT_OUT_W-1:0]        rsp_slot_index,
   output logic [COUNT_OUT_W-1:0]       rsp_entry_count,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int NW = SW + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      table_size_ff;
   logic [NW-1:0]          count_ff, count_in;
   logic [SW-1:0]          clr_ff;
   logic [SW-1:0]          pos_ff, pos_in;
   logic [NW-1:0]          step_ff, step_in;
   logic [OP_W-1:0]        op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [HANDLE_W-1:0]    handle_ff;
   logic [NW-1:0]          n_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [HANDLE_W-1:0]    found_ff;
   logic [SLOT_OUT_W-1:0]  slot_ff;
   logic [COUNT_OUT_W-1:0] entry_ff;

   slot_type               slot_mem [MAX_SLOTS];
   slot_type               rd_ff;
   slot_type               wr_data;
   logic                   wr_en;
   logic [SW-1:0]          wr_addr;
   logic                   rd_en;
   logic [SW-1:0]          rd_addr;

   logic [NW+7:0]          size_wide;
   logic [NW+7:0]          n_wide;
   logic [NW-1:0]          n_act;
   logic                   req_accept;
   logic                   csr_write;
   logic                   mod_done;
   logic [SW-1:0]          mod_rem;
   logic                   out_free;
   logic                   last_step;
   logic                   key_hit;
   logic                   take;
   logic                   finish;
   logic                   fire;
   logic                   advance;
   logic [SW-1:0]          pos_next;
   logic [STATUS_W-1:0]    res_status;
   logic [HANDLE_W-1:0]    res_found;
   logic [SW+6:0]          pos_wide;
   logic [NW+7:0]          count_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_TABLE_SIZE);
   assign csr_prdata = (csr_paddr == CSR_TABLE_SIZE) ? {24'd0, table_size_ff} : 32'd0;

   // Clamp the size register into 1 .. MAX_SLOTS.
   always_comb begin
      size_wide = {{NW{1'b0}}, table_size_ff};
      if (table_size_ff == '0) begin
         n_wide = (NW + 8)'(1);
      end else if (size_wide > (NW + 8)'(MAX_SLOTS)) begin
         n_wide = (NW + 8)'(MAX_SLOTS);
      end else begin
         n_wide = size_wide;
      end
      n_act = n_wide[NW-1:0];
   end

   lpht_mod #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .dividend  (req_lookup_key),
      .divisor   (n_act),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Probe decision on the slot held in the read register.
   always_comb begin
      last_step  = (step_ff == n_ff - 1'b1);
      key_hit    = (rd_ff.mark == MARK_LIVE) && (rd_ff.key == key_ff);
      pos_next   = ({1'b0, pos_ff} == n_ff - 1'b1) ? '0 : pos_ff + 1'b1;
      take       = 1'b0;
      finish     = 1'b0;
      res_status = STATUS_MISS;
      res_found  = '0;
      case (op_ff)
         OP_INSERT: begin
            take   = (rd_ff.mark != MARK_LIVE);
            finish = take || last_step;
            res_status = take ? STATUS_DONE : STATUS_FULL;
         end
         OP_SEARCH: begin
            take   = key_hit;
            finish = key_hit || (rd_ff.mark == MARK_EMPTY) || last_step;
            res_status = key_hit ? STATUS_DONE : STATUS_MISS;
            res_found  = key_hit ? rd_ff.handle : '0;
         end
         OP_DELETE: begin
            take   = key_hit;
            finish = key_hit || (rd_ff.mark == MARK_EMPTY) || last_step;
            res_status = key_hit ? STATUS_DONE : STATUS_MISS;
         end
         default: begin
            finish = 1'b1;
         end
      endcase
      fire    = (state_ff == ST_PROBE) && finish && out_free;
      advance = (state_ff == ST_PROBE) && !finish;
   end

   // Memory port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = rd_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '{mark: MARK_EMPTY, key: '0, handle: '0};
      end else if (fire && take && op_ff == OP_INSERT) begin
         wr_en   = 1'b1;
         wr_data = '{mark: MARK_LIVE, key: key_ff, handle: handle_ff};
      end else if (fire && take && op_ff == OP_DELETE) begin
         wr_en      = 1'b1;
         wr_data.mark = MARK_GONE;
      end
      rd_en   = (state_ff == ST_HASH && mod_done) || advance;
      rd_addr = (state_ff == ST_HASH) ? mod_rem : pos_next;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   // Next state and counters.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SW'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               pos_in   = mod_rem;
               step_in  = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (advance) begin
               pos_in  = pos_next;
               step_in = step_ff + 1'b1;
            end else if (fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (take && op_ff == OP_INSERT) begin
                  count_in = count_ff + 1'b1;
               end else if (take && op_ff == OP_DELETE && count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_write) begin
            table_size_ff <= csr_pwdata[SIZE_W-1:0];
         end
      end
   end

   // Payload registers.
   always_comb begin
      pos_wide   = {7'd0, pos_ff};
      count_wide = {8'd0, count_in};
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      step_ff <= step_in;
      if (req_accept) begin
         op_ff     <= req_operation;
         key_ff    <= req_lookup_key;
         handle_ff <= req_entry_handle;
         n_ff      <= n_act;
      end
      if (fire) begin
         status_ff <= res_status;
         found_ff  <= res_found;
         slot_ff   <= take ? pos_wide[SLOT_OUT_W-1:0] : '0;
         entry_ff  <= (count_wide > (NW + 8)'(255)) ? 8'hFF : count_wide[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_handle = found_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_entry_count  = entry_ff;

endmodule
`default_nettype wire

@@ design/lpht_checker.sv @@
`default_nettype none
`include "linear_probe_hash_table_unit_assert.svh"
module lpht_checker
   import lpht_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [STATUS_W-1:0]   rsp_status,
   input wire logic [HANDLE_W-1:0]   rsp_found_handle,
   input wire logic [SLOT_OUT_W-1:0] rsp_slot_index
);

   logic miss_dirty;

   assign miss_dirty = (rsp_found_handle != '0) || (rsp_slot_index != '0);

   `LPHT_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
   `LPHT_CHECK(a_miss_clean, rsp_valid && rsp_status != STATUS_DONE |-> !miss_dirty)
   `LPHT_CHECK(a_status_code, rsp_valid |-> rsp_status <= STATUS_FULL)
   `LPHT_CHECK_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid)

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);
`default_nettype wire

@@ verif/tb_linear_probe_hash_table_unit.sv @@
`timescale 1ns / 1ps
module tb_linear_probe_hash_table_unit
   import lpht_pkg::*;
();

   localparam int SLOTS      = MAX_SLOTS_DEFAULT;
   localparam int STALL_STOP = 20000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } table_op_type;

   typedef struct {
      logic [STATUS_W-1:0]    status;
      logic [HANDLE_W-1:0]    handle;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [COUNT_OUT_W-1:0] count;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_operation = '0;
   logic [KEY_W-1:0] req_lookup_key = '0;
   logic [HANDLE_W-1:0] req_entry_handle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   linear_probe_hash_table_unit DUT (.*);

   // shadow table
   logic [KEY_W-1:0]    shadow_keys [SLOTS];
   logic [HANDLE_W-1:0] shadow_handles [SLOTS];
   logic [MARK_W-1:0]   shadow_marks [SLOTS];
   int unsigned         shadow_live = 0;
   logic [SIZE_W-1:0]   shadow_size = TABLE_SIZE_RESET;

   table_op_type    pending_ops[$];
   table_reply_type expected_replies[$];
   logic [KEY_W-1:0] key_pool[$];

   int  errors = 0;
   int  ops_sent = 0;
   int  replies_checked = 0;
   int  table_full_seen = 0;
   int  sizes_tried = 0;
   bit  calm = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic table_reply_type apply_table_op(table_op_type t);
      table_reply_type r;
      int unsigned n;
      int unsigned pos;
      bit hit;
      n = (shadow_size == 0) ? 1 : (shadow_size > SLOTS) ? SLOTS : shadow_size;
      r.status = STATUS_MISS;
      r.handle = '0;
      r.slot = '0;
      pos = 32'(t.key % KEY_W'(n));
      hit = 1'b0;
      if (t.op == OP_INSERT) begin
         r.status = STATUS_FULL;
         for (int s = 0; s < n; s++) begin
            if (shadow_marks[pos] != MARK_LIVE) begin
               shadow_keys[pos] = t.key;
               shadow_handles[pos] = t.handle;
               shadow_marks[pos] = MARK_LIVE;
               shadow_live++;
               r.status = STATUS_DONE;
               r.slot = SLOT_OUT_W'(pos);
               break;
            end
            pos = (pos + 1 == n) ? 0 : pos + 1;
         end
      end else if (t.op == OP_SEARCH || t.op == OP_DELETE) begin
         for (int s = 0; s < n; s++) begin
            if (shadow_marks[pos] == MARK_EMPTY) break;
            if (shadow_marks[pos] == MARK_LIVE && shadow_keys[pos] == t.key) begin
               hit = 1'b1;
               break;
            end
            pos = (pos + 1 == n) ? 0 : pos + 1;
         end
         if (hit) begin
            r.status = STATUS_DONE;
            r.slot = SLOT_OUT_W'(pos);
            if (t.op == OP_SEARCH) begin
               r.handle = shadow_handles[pos];
            end else begin
               shadow_marks[pos] = MARK_GONE;
               if (shadow_live > 0) shadow_live--;
            end
         end
      end
      r.count = (shadow_live > 255) ? 8'd255 : shadow_live[7:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      table_op_type t;
      bit next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            t.op = req_operation;
            t.key = req_lookup_key;
            t.handle = req_entry_handle;
            expected_replies = {expected_replies, apply_table_op(t)};
            ops_sent++;
         end
         next_valid = req_valid && req_stall;
         if (!next_valid && pending_ops.size() > 0
             && (calm || $urandom_range(99) >= 31)) begin
            t = pending_ops.pop_front();
            req_operation <= t.op;
            req_lookup_key <= t.key;
            req_entry_handle <= t.handle;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      table_reply_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected: status %0d slot %0d", $time,
                        rsp_status, rsp_slot_index);
               errors++;
            end else begin
               e = expected_replies.pop_front();
               if (e.status == STATUS_FULL) table_full_seen++;
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
                  errors++;
               end
               if (rsp_found_handle !== e.handle) begin
                  $display("%0t: found_handle expected %h actual %h", $time, e.handle,
                           rsp_found_handle);
                  errors++;
               end
               if (rsp_slot_index !== e.slot) begin
                  $display("%0t: slot_index expected %0d actual %0d", $time, e.slot,
                           rsp_slot_index);
                  errors++;
               end
               if (rsp_entry_count !== e.count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time, e.count,
                           rsp_entry_count);
                  errors++;
               end
            end
            replies_checked++;
         end
         // one long hold-off to back the block up
         if (!hold_done && replies_checked == 400) begin
            hold_done = 1'b1;
            hold_left = 1500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 31);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_STOP) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_STOP);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_table_size(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_TABLE_SIZE;
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shadow_size = value;
      sizes_tried++;
   endtask

   task automatic queue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle);
      table_op_type t;
      t.op = op;
      t.key = key;
      t.handle = handle;
      pending_ops = {pending_ops, t};
      if (op == OP_INSERT) begin
         key_pool = {key_pool, key};
         if (key_pool.size() > 40) void'(key_pool.pop_front());
      end
   endtask

   task automatic drain;
      do @(posedge clock); while (pending_ops.size() > 0 || req_valid);
      while (expected_replies.size() > 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key(bit from_pool);
      logic [63:0] wide;
      if (from_pool && key_pool.size() > 0)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      wide = {$urandom, $urandom};
      return ($urandom_range(1)) ? KEY_W'($urandom_range(400)) : wide[KEY_W-1:0];
   endfunction

   task automatic queue_random_ops(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 40)
            queue_op(OP_INSERT, pick_key($urandom_range(3) == 0), $urandom);
         else if (r < 70)
            queue_op(OP_SEARCH, pick_key($urandom_range(3) != 0), $urandom);
         else if (r < 93)
            queue_op(OP_DELETE, pick_key($urandom_range(3) != 0), $urandom);
         else
            queue_op(OP_W'($urandom_range(3)), pick_key(0), $urandom);
      end
   endtask

   initial begin
      logic [7:0] sizes [11] = '{8'd5, 8'd0, 8'd1, 8'd128, 8'd2, 8'd200, 8'd7,
                                 8'd255, 8'd64, 8'd3, 8'd17};
      for (int i = 0; i < SLOTS; i++) shadow_marks[i] = MARK_EMPTY;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extremes, collisions past a deleted mark, duplicates, unknown op
      queue_op(OP_INSERT, '0, '0);
      queue_op(OP_INSERT, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
      queue_op(OP_SEARCH, '0, '0);
      queue_op(OP_SEARCH, {KEY_W{1'b1}}, '0);
      queue_op(OP_INSERT, 50'd17, 32'h1111_0017);
      queue_op(OP_INSERT, 50'd34, 32'h2222_0034);
      queue_op(OP_INSERT, 50'd17, 32'h3333_0017);
      queue_op(OP_DELETE, 50'd17, '0);
      queue_op(OP_SEARCH, 50'd34, '0);
      queue_op(OP_SEARCH, 50'd17, '0);
      queue_op(OP_SEARCH, 50'd51, '0);
      queue_op(OP_DELETE, 50'd999, '0);
      queue_op(OP_UNUSED, 50'd34, 32'hDEAD_BEEF);
      queue_op(OP_INSERT, 50'd51, 32'h5151_5151);
      drain();
      write_table_size(8'd1);
      queue_op(OP_INSERT, 50'd5, 32'hA5A5_A5A5);
      queue_op(OP_INSERT, 50'd6, 32'h5A5A_5A5A);
      queue_op(OP_SEARCH, 50'd5, '0);
      queue_op(OP_DELETE, 50'd5, '0);
      queue_op(OP_INSERT, 50'd6, 32'h0000_0006);
      drain();

      foreach (sizes[i]) begin
         calm = (i == 3);
         write_table_size(sizes[i]);
         queue_random_ops(148);
         drain();
      end
      calm = 1'b0;

      repeat (300) @(posedge clock);
      $display("%0d operations over %0d table sizes, %0d replies checked, %0d full-table",
               ops_sent, sizes_tried, replies_checked, table_full_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/lpht_pkg.sv
design/lpht_mod.sv
design/linear_probe_hash_table_unit.sv
design/lpht_checker.sv
verif/tb_linear_probe_hash_table_unit.sv
